@@ design/pci_config_space_with_bar_decode_core_assert.svh @@
// Assertion helpers shared by the configuration space design.
// Each macro expands to one labeled concurrent assertion that is
// disabled while the synchronous reset is held.
`ifndef PCI_CONFIG_SPACE_WITH_BAR_DECODE_CORE_ASSERT_SVH
`define PCI_CONFIG_SPACE_WITH_BAR_DECODE_CORE_ASSERT_SVH

// Same-cycle implication.
`define PCICFG_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("configuration space assertion failed");

// Next-cycle implication.
`define PCICFG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("configuration space assertion failed");

`endif

@@ design/pcicfg_pkg.sv @@
package pcicfg_pkg;

    localparam int NUM_REGIONS_DEF = 7;
    localparam int SPACE_BYTES_DEF = 256;
    localparam int RAM_WIDTH_DEF   = 32;

    // Slot that holds the expansion ROM register.
    localparam logic [2:0] ROM_REGION = 3'd6;

    // Header layout.
    localparam logic [7:0] ID_LAST          = 8'h03;
    localparam logic [7:0] CLASS_FIRST      = 8'h08;
    localparam logic [7:0] CLASS_LAST       = 8'h0b;
    localparam logic [7:0] HDR_KIND_BYTE    = 8'h0e;
    localparam logic [7:0] BAR_FIRST        = 8'h10;
    localparam logic [7:0] BAR_END          = 8'h10 + 8'd4 * 8'd6;
    localparam logic [7:0] ROM_FIRST        = 8'h30;
    localparam logic [7:0] ROM_END          = 8'h34;
    localparam logic [7:0] BRIDGE_ROM_FIRST = 8'h38;
    localparam logic [7:0] BRIDGE_ROM_LAST  = 8'h3b;
    localparam logic [7:0] INT_PIN_BYTE     = 8'h3d;
    localparam logic [7:0] CMD_WORD_FIRST   = 8'h04;
    localparam logic [7:0] CMD_WORD_END     = 8'h06;
    localparam logic [6:0] CMD_DWORD        = 7'd1;
    localparam logic [6:0] HDR_DWORD        = 7'd3;

    localparam logic [7:0] HDR_DEVICE       = 8'h00;
    localparam logic [7:0] HDR_MULTI_DEVICE = 8'h80;

    localparam logic [31:0] IO_LIMIT = 32'h0001_0000;
    localparam logic [31:0] ALL_ONES = 32'hffff_ffff;

    localparam logic [2:0] MAX_LENGTH = 3'd4;

    localparam logic CMD_READ    = 1'b0;
    localparam logic CMD_WRITE   = 1'b1;
    localparam logic ITEM_DONE   = 1'b0;
    localparam logic ITEM_CHANGE = 1'b1;

    typedef logic [1:0] t_cfg_index;
    localparam t_cfg_index CFG_SIZES = 2'd0;
    localparam t_cfg_index CFG_KINDS = 2'd1;
    localparam t_cfg_index CFG_HDR   = 2'd2;

    typedef struct packed {
        logic        cmd;
        logic [7:0]  byte_address;
        logic [31:0] write_data;
        logic [2:0]  access_length;
    } t_req;

    typedef struct packed {
        logic [31:0] read_data;
        logic        item_kind;
        logic [2:0]  region_number;
        logic [31:0] region_base;
        logic        region_mapped;
        logic        last;
    } t_rsp;

    typedef struct packed {
        t_cfg_index  reg_index;
        logic [41:0] write_value;
    } t_cfg;

    // Controls for the shared region decode unit.
    typedef struct packed {
        logic [5:0] size_log;
        logic [3:0] kind;
        logic       is_rom;
        logic       cmd_io;
        logic       cmd_mem;
    } t_dec_ctl;

    // Mask of the address bits inside a region; size_log is at most 32.
    function automatic logic [31:0] low_mask(input logic [5:0] size_log);
        logic [32:0] one_hot;
        one_hot = 33'h1 << size_log;
        return 32'(one_hot - 33'h1);
    endfunction

    function automatic logic [7:0] reg_offset(input logic [2:0] region);
        return (region == ROM_REGION) ? ROM_FIRST : BAR_FIRST + {3'b000, region, 2'b00};
    endfunction

    function automatic logic read_only(input logic [7:0] a, input logic device);
        logic fixed;
        fixed = (a <= ID_LAST) || (a >= CLASS_FIRST && a <= CLASS_LAST) ||
                (a == HDR_KIND_BYTE) || (a == INT_PIN_BYTE);
        if (fixed) begin
            return 1'b1;
        end
        if (device) begin
            return (a >= BAR_FIRST && a < BAR_END) || (a >= ROM_FIRST && a < ROM_END);
        end
        return a >= BRIDGE_ROM_FIRST && a <= BRIDGE_ROM_LAST;
    endfunction

endpackage

@@ design/pcicfg_stream_if.sv @@
interface pcicfg_stream_if #(
    parameter type T_PAYLOAD = logic
) ();
    logic     valid;
    logic     ready;
    T_PAYLOAD data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ design/pcicfg_ram.sv @@
module pcicfg_ram
    import pcicfg_pkg::*;
#(
    parameter int WIDTH = RAM_WIDTH_DEF,
    parameter int DEPTH = SPACE_BYTES_DEF / 4
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/pcicfg_decode.sv @@
module pcicfg_decode
    import pcicfg_pkg::*;
(
    input  logic        i_clk,
    input  t_dec_ctl    i_ctl,
    input  logic [31:0] i_raw,
    output logic [31:0] o_base
);

    logic [31:0] mask;
    logic [31:0] base;
    logic [31:0] top_addr;
    logic        io_bad;
    logic        mem_bad;
    logic [31:0] r_base;

    // The base keeps the register bits above the region size; the region is
    // dropped when it is disabled, starts at zero, wraps or hits its limit.
    always_comb begin
        mask     = low_mask(i_ctl.size_log);
        base     = i_raw & ~mask;
        top_addr = base + mask;
        io_bad   = !i_ctl.cmd_io || (top_addr <= base) || (base == '0) ||
                   (top_addr >= IO_LIMIT);
        mem_bad  = !i_ctl.cmd_mem || (i_ctl.is_rom && !i_raw[0]) ||
                   (top_addr <= base) || (base == '0) || (top_addr == ALL_ONES);
    end

    always_ff @(posedge i_clk) begin
        r_base <= (i_ctl.kind[0] ? io_bad : mem_bad) ? ALL_ONES : base;
    end

    assign o_base = r_base;

endmodule

@@ design/pci_config_space_with_bar_decode_core.sv @@
// Sequence: a read passes S_RD_HI, S_MERGE and S_DONE; a write without
// remapping adds S_WR_LO and S_WR_HI before S_DONE; a write that remaps
// then adds S_UPD_CMD and S_UPD_CMDW, then S_UPD_NEXT for each region and
// S_UPD_EVAL and S_UPD_EMIT for each present one. Throughput: one item at a
// time; the dword RAM port and the shared region decode unit are reused step
// by step, and output stalls extend the item. Reset: synchronous, active low;
// the space reads as zero, every region is unmapped, the registers are zero;
// a region size or kind write sweeps the region registers before the next item.
module pci_config_space_with_bar_decode_core
    import pcicfg_pkg::*;
#(
    parameter int NUM_REGIONS = NUM_REGIONS_DEF,
    parameter int SPACE_BYTES = SPACE_BYTES_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    pcicfg_stream_if.sink   i_req,
    pcicfg_stream_if.sink   i_cfg,
    pcicfg_stream_if.source o_rsp
);

    // The space is held as dwords in one RAM. Every dword has a valid bit so
    // that a dword never written since reset reads as zero without a clearing
    // pass. Byte 0x0e always reads back the header kind register.
    localparam int DEPTH = SPACE_BYTES / 4;
    localparam int AW    = $clog2(DEPTH);

    localparam logic [2:0] LAST_REGION = 3'(NUM_REGIONS);
    localparam logic [8:0] SPACE_END   = 9'(SPACE_BYTES);
    localparam logic [6:0] DEPTH_W     = 7'(DEPTH);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_RD_HI    = 4'd1;
    localparam logic [3:0] S_MERGE    = 4'd2;
    localparam logic [3:0] S_WR_LO    = 4'd3;
    localparam logic [3:0] S_WR_HI    = 4'd4;
    localparam logic [3:0] S_UPD_CMD  = 4'd5;
    localparam logic [3:0] S_UPD_CMDW = 4'd6;
    localparam logic [3:0] S_UPD_NEXT = 4'd7;
    localparam logic [3:0] S_UPD_EVAL = 4'd8;
    localparam logic [3:0] S_UPD_EMIT = 4'd9;
    localparam logic [3:0] S_DONE     = 4'd10;
    localparam logic [3:0] S_SWEEP    = 4'd11;

    // Control state.
    logic [3:0]       r_state;
    logic [3:0]       n_state;
    logic [2:0]       r_idx;
    logic [2:0]       n_idx;
    logic [41:0]      r_sizes;
    logic [27:0]      r_kinds;
    logic [7:0]       r_hdr;
    logic [DEPTH-1:0] r_dw_valid;
    logic [31:0]      r_base [0:NUM_REGIONS-1];
    logic             r_out_valid;

    // Item context and datapath.
    logic        r_write;
    logic [7:0]  r_addr;
    logic [2:0]  r_len;
    logic [31:0] r_wdata;
    logic        r_regpath;
    logic        r_upd;
    logic [31:0] r_lo;
    logic [31:0] r_wlo;
    logic [31:0] r_whi;
    logic        r_en_lo;
    logic        r_en_hi;
    logic [31:0] r_rdata;
    logic [1:0]  r_cmdw;
    logic        r_q_ok;
    logic        r_q_hdr;
    t_rsp        r_out;

    logic req_acc;
    logic cfg_acc;
    logic slot_free;
    logic device;

    // Per-region fields; slots at or beyond NUM_REGIONS are absent.
    logic [5:0] size_of [0:7];
    logic [3:0] kind_of [0:7];

    for (genvar gi = 0; gi < 8; gi++) begin : g_fld
        if (gi < NUM_REGIONS) begin : g_on
            assign size_of[gi] = (r_sizes[6*gi +: 6] > 6'd32) ? 6'd32 : r_sizes[6*gi +: 6];
            assign kind_of[gi] = r_kinds[4*gi +: 4];
        end else begin : g_off
            assign size_of[gi] = '0;
            assign kind_of[gi] = '0;
        end
    end

    assign i_cfg.ready = (r_state == S_IDLE);
    assign i_req.ready = (r_state == S_IDLE) && !i_cfg.valid;
    assign cfg_acc     = i_cfg.valid && i_cfg.ready;
    assign req_acc     = i_req.valid && i_req.ready;
    assign slot_free   = !r_out_valid || o_rsp.ready;
    assign device      = (r_hdr == HDR_DEVICE) || (r_hdr == HDR_MULTI_DEVICE);

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

    // ------------------------------------------------------------------
    // Acceptance: clamp the length, spot a 4-byte base register write to a
    // present region and apply its size mask and type or enable bits now.
    // ------------------------------------------------------------------
    logic [7:0]  in_addr;
    logic [2:0]  in_len;
    logic [7:0]  in_rel;
    logic [2:0]  in_reg;
    logic        in_bar;
    logic [31:0] in_mask;
    logic [31:0] in_regval;
    logic        in_regpath;
    logic        in_touch_cmd;

    always_comb begin
        in_addr   = i_req.data.byte_address;
        in_len    = (i_req.data.access_length > MAX_LENGTH) ? MAX_LENGTH
                                                            : i_req.data.access_length;
        in_rel    = in_addr - BAR_FIRST;
        in_reg    = (in_addr >= ROM_FIRST) ? ROM_REGION : in_rel[4:2];
        in_bar    = (in_addr >= BAR_FIRST && in_addr < BAR_END) ||
                    (in_addr >= ROM_FIRST && in_addr < ROM_END);
        in_mask   = low_mask(size_of[in_reg]);
        if (in_reg == ROM_REGION) begin
            in_regval = i_req.data.write_data & (~in_mask | 32'h1);
        end else begin
            in_regval = (i_req.data.write_data & ~in_mask) | {28'b0, kind_of[in_reg]};
        end
        in_regpath   = (i_req.data.cmd == CMD_WRITE) && (in_len == MAX_LENGTH) && in_bar &&
                       (size_of[in_reg] != '0);
        in_touch_cmd = ({1'b0, in_addr} + {6'b0, in_len} > {1'b0, CMD_WORD_FIRST}) &&
                       (in_addr < CMD_WORD_END);
    end

    // ------------------------------------------------------------------
    // RAM and read data. The read data is qualified by the valid bit and the
    // range check taken when its address was issued.
    // ------------------------------------------------------------------
    logic [6:0]    rd_idx;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [31:0]   ram_wdata;
    logic [31:0]   ram_q;
    logic [31:0]   dw;
    logic [6:0]    lo_idx;
    logic [6:0]    hi_idx;
    logic [7:0]    cur_off;

    assign lo_idx  = {1'b0, r_addr[7:2]};
    assign hi_idx  = lo_idx + 7'd1;
    assign cur_off = reg_offset(r_idx);

    pcicfg_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (rd_idx[AW-1:0]),
        .o_rdata (ram_q)
    );

    always_comb begin
        dw = r_q_ok ? ram_q : '0;
        if (r_q_hdr) begin
            dw[23:16] = r_hdr;
        end
    end

    // ------------------------------------------------------------------
    // Byte merge over the two dwords an access can span. Reads shift the
    // window down; writes shift the data up and pick writable bytes.
    // ------------------------------------------------------------------
    logic [63:0] win;
    logic [63:0] rwin;
    logic [63:0] wd64;
    logic [63:0] merged;
    logic [7:0]  byte_en;
    logic [31:0] rd_word;
    logic [5:0]  shamt;

    always_comb begin
        logic [8:0] a9;
        logic [2:0] kk;
        win   = {dw, r_lo};
        shamt = {1'b0, r_addr[1:0], 3'b000};
        rwin  = win >> shamt;
        wd64  = {32'b0, r_wdata} << shamt;
        for (int k = 0; k < 4; k++) begin
            rd_word[8*k +: 8] = (3'(k) < r_len) ? rwin[8*k +: 8] : 8'h00;
        end
        for (int p = 0; p < 8; p++) begin
            a9 = {1'b0, r_addr[7:2], 2'b00} + 9'(p);
            kk = 3'(p) - {1'b0, r_addr[1:0]};
            byte_en[p] = (3'(p) >= {1'b0, r_addr[1:0]}) && (kk < r_len) &&
                         (a9 < SPACE_END) && (r_regpath || !read_only(a9[7:0], device));
            merged[8*p +: 8] = byte_en[p] ? wd64[8*p +: 8] : win[8*p +: 8];
        end
    end

    // ------------------------------------------------------------------
    // Shared region decode unit, one region per pass.
    // ------------------------------------------------------------------
    t_dec_ctl    dec_ctl;
    logic [31:0] dec_base;
    logic        changed;

    assign dec_ctl.size_log = size_of[r_idx];
    assign dec_ctl.kind     = kind_of[r_idx];
    assign dec_ctl.is_rom   = (r_idx == ROM_REGION);
    assign dec_ctl.cmd_io   = r_cmdw[0];
    assign dec_ctl.cmd_mem  = r_cmdw[1];

    pcicfg_decode u_decode (
        .i_clk  (i_clk),
        .i_ctl  (dec_ctl),
        .i_raw  (dw),
        .o_base (dec_base)
    );

    assign changed = (dec_base != r_base[r_idx]);

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    logic out_load;
    t_rsp out_item;
    logic base_we;

    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        rd_idx    = '0;
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        out_load  = 1'b0;
        out_item  = '0;
        base_we   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                rd_idx = {1'b0, i_req.data.byte_address[7:2]};
                if (cfg_acc) begin
                    if (i_cfg.data.reg_index == CFG_SIZES ||
                        i_cfg.data.reg_index == CFG_KINDS) begin
                        n_idx   = '0;
                        n_state = S_SWEEP;
                    end
                end else if (req_acc) begin
                    n_state = S_RD_HI;
                end
            end
            S_RD_HI: begin
                rd_idx  = hi_idx;
                n_state = S_MERGE;
            end
            S_MERGE: begin
                n_state = r_write ? S_WR_LO : S_DONE;
            end
            S_WR_LO: begin
                ram_we    = r_en_lo;
                ram_waddr = lo_idx[AW-1:0];
                ram_wdata = r_wlo;
                n_state   = S_WR_HI;
            end
            S_WR_HI: begin
                ram_we    = r_en_hi;
                ram_waddr = hi_idx[AW-1:0];
                ram_wdata = r_whi;
                n_state   = r_upd ? S_UPD_CMD : S_DONE;
            end
            S_UPD_CMD: begin
                rd_idx  = CMD_DWORD;
                n_state = S_UPD_CMDW;
            end
            S_UPD_CMDW: begin
                n_idx   = '0;
                n_state = S_UPD_NEXT;
            end
            S_UPD_NEXT: begin
                if (r_idx == LAST_REGION) begin
                    n_state = S_DONE;
                end else if (size_of[r_idx] == '0) begin
                    n_idx = r_idx + 3'd1;
                end else begin
                    rd_idx  = {1'b0, cur_off[7:2]};
                    n_state = S_UPD_EVAL;
                end
            end
            S_UPD_EVAL: begin
                // Keep reading the register dword so the decode input holds
                // steady while a change item waits for the output.
                rd_idx  = {1'b0, cur_off[7:2]};
                n_state = S_UPD_EMIT;
            end
            S_UPD_EMIT: begin
                rd_idx = {1'b0, cur_off[7:2]};
                if (!changed) begin
                    n_idx   = r_idx + 3'd1;
                    n_state = S_UPD_NEXT;
                end else if (slot_free) begin
                    out_load               = 1'b1;
                    out_item.item_kind     = ITEM_CHANGE;
                    out_item.region_number = r_idx;
                    out_item.region_base   = dec_base;
                    out_item.region_mapped = (dec_base != ALL_ONES);
                    base_we                = 1'b1;
                    n_idx                  = r_idx + 3'd1;
                    n_state                = S_UPD_NEXT;
                end
            end
            S_DONE: begin
                if (slot_free) begin
                    out_load           = 1'b1;
                    out_item.read_data = r_rdata;
                    out_item.item_kind = ITEM_DONE;
                    out_item.last      = 1'b1;
                    n_state            = S_IDLE;
                end
            end
            S_SWEEP: begin
                // Present regions get their register dword set to the type.
                if (r_idx == LAST_REGION) begin
                    n_state = S_IDLE;
                end else begin
                    ram_we    = (size_of[r_idx] != '0);
                    ram_waddr = cur_off[AW+1:2];
                    ram_wdata = {28'b0, kind_of[r_idx]};
                    n_idx     = r_idx + 3'd1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_sizes     <= '0;
            r_kinds     <= '0;
            r_hdr       <= '0;
            r_dw_valid  <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_REGIONS; i++) begin
                r_base[i] <= ALL_ONES;
            end
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            if (cfg_acc) begin
                unique case (i_cfg.data.reg_index)
                    CFG_SIZES: r_sizes <= i_cfg.data.write_value;
                    CFG_KINDS: r_kinds <= i_cfg.data.write_value[27:0];
                    CFG_HDR:   r_hdr   <= i_cfg.data.write_value[7:0];
                    default: begin
                    end
                endcase
                if (i_cfg.data.reg_index == CFG_SIZES ||
                    i_cfg.data.reg_index == CFG_KINDS) begin
                    for (int i = 0; i < NUM_REGIONS; i++) begin
                        r_base[i] <= ALL_ONES;
                    end
                end
            end
            if (base_we) begin
                r_base[r_idx] <= dec_base;
            end
            if (ram_we) begin
                r_dw_valid[ram_waddr] <= 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_q_ok  <= (rd_idx < DEPTH_W) && r_dw_valid[rd_idx[AW-1:0]];
        r_q_hdr <= (rd_idx == HDR_DWORD);
        if (req_acc) begin
            r_write   <= (i_req.data.cmd == CMD_WRITE);
            r_addr    <= in_addr;
            r_len     <= in_len;
            r_wdata   <= in_regpath ? in_regval : i_req.data.write_data;
            r_regpath <= in_regpath;
            r_upd     <= (i_req.data.cmd == CMD_WRITE) && (in_regpath || in_touch_cmd);
        end
        if (r_state == S_RD_HI) begin
            r_lo <= dw;
        end
        if (r_state == S_MERGE) begin
            r_rdata <= r_write ? 32'h0 : rd_word;
            r_wlo   <= merged[31:0];
            r_whi   <= merged[63:32];
            r_en_lo <= |byte_en[3:0];
            r_en_hi <= |byte_en[7:4];
        end
        if (r_state == S_UPD_CMDW) begin
            r_cmdw <= dw[1:0];
        end
        if (out_load) begin
            r_out <= out_item;
        end
    end

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
`include "pci_config_space_with_bar_decode_core_assert.svh"

    `PCICFG_ASSERT_IMPL(a_only_change_not_last, i_clk, i_rst_n, o_rsp.valid && !o_rsp.data.last, o_rsp.data.item_kind == ITEM_CHANGE)
    `PCICFG_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, req_acc, !i_req.ready)
    `PCICFG_ASSERT_NEXT(a_sweep_blocks_items, i_clk, i_rst_n, cfg_acc && (i_cfg.data.reg_index == CFG_SIZES || i_cfg.data.reg_index == CFG_KINDS), !i_req.ready && !i_cfg.ready)
    `PCICFG_ASSERT_IMPL(a_emit_index_range, i_clk, i_rst_n, r_state == S_UPD_EMIT, r_idx < LAST_REGION)

endmodule
